>>> rtl/tkprt_pkg.sv
// Shared types and constants for the touch key press and repeat tracker.
package tkprt_pkg;

  // Field widths fixed by the interface
  localparam int unsigned KEY_W   = 6;
  localparam int unsigned RAW_W   = 22;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned CDATA_W = 16;

  // Largest number of keys that a key code can address
  localparam int unsigned CODE_KEYS = 64;

  // Touch threshold 1.1 as the ratio 11 / 10
  localparam int unsigned TOUCH_W = RAW_W + 4;
  localparam logic [3:0]  THR_NUM = 4'd11;
  localparam logic [3:0]  THR_DEN = 4'd10;

  // Event kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_DOWN  = 2'd0,
    KIND_UP    = 2'd1,
    KIND_TYPED = 2'd2
  } event_kind_t;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_REPEAT_DELAY  = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_REPEAT_REWIND = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_SHIFT_KEY     = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_ZERO_KEY      = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_SPACE_KEY     = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_DELETE_CODE   = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_BREAK_CODE    = 3'd6;

  // Reset values of the configuration registers
  localparam logic [MS_W-1:0]  RST_REPEAT_DELAY  = 16'd500;
  localparam logic [MS_W-1:0]  RST_REPEAT_REWIND = 16'd400;
  localparam logic [KEY_W-1:0] RST_SHIFT_KEY     = 6'd0;
  localparam logic [KEY_W-1:0] RST_ZERO_KEY      = 6'd1;
  localparam logic [KEY_W-1:0] RST_SPACE_KEY     = 6'd2;
  localparam logic [KEY_W-1:0] RST_DELETE_CODE   = 6'd3;
  localparam logic [KEY_W-1:0] RST_BREAK_CODE    = 6'd4;

  // One result word
  typedef struct packed {
    event_kind_t      kind;
    logic [KEY_W-1:0] code;
    logic             last;
  } result_t;

endpackage

>>> rtl/touch_key_press_repeat_tracker_unit.sv
// Top level of the touch key press and auto-repeat tracker.
//
// Takes one scanned touch sample per cycle while stage 1 can retire, and
// reports key-down, key-up and typed words. A sample is touched when raw*10 >
// baseline*11. Press stamps live in a 32-bit wide synchronous RAM, one entry
// per key, read when the sample is taken and written back when it retires
// from stage 1; a same-key sample taken as the earlier one retires sees the new
// stamp through a forwarding register. Held flags are flip-flops cleared by
// reset, so the stamp RAM needs no clearing pass. A new touch yields two words,
// and the output side delivers one word per cycle while out_ready is high.
// A word enters a four-word output queue, between the update stage and
// out_valid/out_ready, when its sample retires from stage 1.
// Key codes at or above NUM_KEYS are ignored. Configuration must be written
// through the cfg port while the block is idle; the block does not enforce it.
module touch_key_press_repeat_tracker_unit
  import tkprt_pkg::*;
#(
  parameter int unsigned NUM_KEYS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  // sample channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [KEY_W-1:0]   in_key_code,
  input  logic [RAW_W-1:0]   in_raw_touch,
  input  logic [RAW_W-1:0]   in_baseline,
  input  logic [TIME_W-1:0]  in_now_ms,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [KIND_W-1:0]  out_event_kind,
  output logic [KEY_W-1:0]   out_event_code,
  output logic               out_last,
  // configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CDATA_W-1:0] cfg_data
);

  localparam int unsigned TABLE_DEPTH = (NUM_KEYS < CODE_KEYS) ? NUM_KEYS : CODE_KEYS;
  localparam int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned PTR_W       = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W       = PTR_W + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [MS_W-1:0]  repeat_delay_r, repeat_rewind_r;
  logic [KEY_W-1:0] shift_key_r, zero_key_r, space_key_r, delete_code_r, break_code_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeat_delay_r  <= RST_REPEAT_DELAY;
      repeat_rewind_r <= RST_REPEAT_REWIND;
      shift_key_r     <= RST_SHIFT_KEY;
      zero_key_r      <= RST_ZERO_KEY;
      space_key_r     <= RST_SPACE_KEY;
      delete_code_r   <= RST_DELETE_CODE;
      break_code_r    <= RST_BREAK_CODE;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_REPEAT_DELAY:  repeat_delay_r  <= cfg_data;
        CFG_REPEAT_REWIND: repeat_rewind_r <= cfg_data;
        CFG_SHIFT_KEY:     shift_key_r     <= cfg_data[KEY_W-1:0];
        CFG_ZERO_KEY:      zero_key_r      <= cfg_data[KEY_W-1:0];
        CFG_SPACE_KEY:     space_key_r     <= cfg_data[KEY_W-1:0];
        CFG_DELETE_CODE:   delete_code_r   <= cfg_data[KEY_W-1:0];
        CFG_BREAK_CODE:    break_code_r    <= cfg_data[KEY_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: take sample, start stamp read, evaluate touch threshold
  logic                in_fire;
  logic                in_range;
  logic [TOUCH_W-1:0]  raw_scaled, base_scaled;
  logic                touched;

  assign in_fire     = in_valid && in_ready;
  assign in_range    = (32'(in_key_code) < NUM_KEYS);
  assign raw_scaled  = TOUCH_W'(in_raw_touch) * TOUCH_W'(THR_DEN);
  assign base_scaled = TOUCH_W'(in_baseline) * TOUCH_W'(THR_NUM);
  assign touched     = raw_scaled > base_scaled;

  logic               s1_valid_r;
  logic [KEY_W-1:0]   s1_key_r;
  logic               s1_range_r;
  logic               s1_touch_r;
  logic [TIME_W-1:0]  s1_now_r;
  logic               s1_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_key_r   <= in_key_code;
      s1_range_r <= in_range;
      s1_touch_r <= touched;
      s1_now_r   <= in_now_ms;
    end
  end

  // ---------------------------------------------------------------------------
  // Stamp RAM with forwarding of a same-cycle write to the same key
  logic [TIME_W-1:0] stamp_mem [TABLE_DEPTH];
  logic [TIME_W-1:0] stamp_rd_r;
  logic [TIME_W-1:0] fwd_data_r;
  logic              fwd_hit_r;
  logic              mem_re, mem_we;
  logic [IDX_W-1:0]  mem_raddr, mem_waddr;
  logic [TIME_W-1:0] mem_wdata;

  assign mem_re    = in_fire && in_range;
  assign mem_raddr = in_key_code[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stamp_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      stamp_rd_r <= stamp_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (mem_re) begin
      fwd_hit_r <= mem_we && (mem_waddr == mem_raddr);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      fwd_data_r <= mem_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: held flags, repeat timing, remap and result words
  logic [TABLE_DEPTH-1:0] held_r;
  logic [IDX_W-1:0]       s1_idx;
  logic                   s1_held;
  logic [TIME_W-1:0]      s1_stamp;
  logic [TIME_W-1:0]      s1_elapsed;
  logic                   new_press, repeat_fire, release_key;
  logic                   shift_range, shift_held;
  logic [KEY_W-1:0]       typed_code, zero_mapped;
  result_t                res0, res1;
  logic [1:0]             push_n;

  assign s1_idx      = s1_key_r[IDX_W-1:0];
  assign s1_held     = s1_range_r && held_r[s1_idx];
  assign s1_stamp    = fwd_hit_r ? fwd_data_r : stamp_rd_r;
  assign s1_elapsed  = s1_now_r - s1_stamp;

  assign new_press   = s1_range_r && s1_touch_r && !s1_held;
  assign repeat_fire = s1_held && s1_touch_r && (s1_elapsed > TIME_W'(repeat_delay_r));
  assign release_key = s1_held && !s1_touch_r;

  // shift counts as held including a press recorded by this very sample
  assign shift_range = (32'(shift_key_r) < NUM_KEYS);
  assign shift_held  = shift_range &&
                       (held_r[shift_key_r[IDX_W-1:0]] ||
                        (new_press && (s1_key_r == shift_key_r)));

  assign zero_mapped = (shift_held && (s1_key_r == zero_key_r)) ? delete_code_r : s1_key_r;
  assign typed_code  = (shift_held && (zero_mapped == space_key_r)) ? break_code_r
                                                                   : zero_mapped;

  always_comb begin
    res0   = '{kind: KIND_TYPED, code: typed_code, last: 1'b1};
    res1   = '{kind: KIND_TYPED, code: typed_code, last: 1'b1};
    push_n = 2'd0;
    if (new_press) begin
      res0   = '{kind: KIND_DOWN, code: s1_key_r, last: 1'b0};
      push_n = 2'd2;
    end else if (release_key) begin
      res0   = '{kind: KIND_UP, code: s1_key_r, last: 1'b1};
      push_n = 2'd1;
    end else if (repeat_fire) begin
      push_n = 2'd1;
    end
  end

  // write back the stamp on a new press or a repeat
  assign mem_we    = s1_done && (new_press || repeat_fire);
  assign mem_waddr = s1_idx;
  assign mem_wdata = new_press ? s1_now_r : (s1_now_r - TIME_W'(repeat_rewind_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (s1_done && (new_press || release_key)) begin
      held_r[s1_idx] <= new_press;
    end
  end

  // ---------------------------------------------------------------------------
  // Output queue: stage 1 retires only with room for two words
  result_t            fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               pop;
  logic               fifo_room;

  assign fifo_room = (count_r <= CNT_W'(FIFO_DEPTH - 2));
  assign s1_done   = s1_valid_r && fifo_room;
  assign in_ready  = !s1_valid_r || fifo_room;

  assign out_valid      = (count_r != '0);
  assign pop            = out_valid && out_ready;
  assign out_event_kind = fifo_r[rd_ptr_r].kind;
  assign out_event_code = fifo_r[rd_ptr_r].code;
  assign out_last       = fifo_r[rd_ptr_r].last;

  assign count_nxt = count_r + CNT_W'(s1_done ? push_n : 2'd0) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (s1_done) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(push_n);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done && (push_n != 2'd0)) begin
      fifo_r[wr_ptr_r] <= res0;
    end
    if (s1_done && (push_n == 2'd2)) begin
      fifo_r[wr_ptr_r + PTR_W'(1)] <= res1;
    end
  end

endmodule
